// ===== src/twrb_pkg.sv =====
// shared types, constants and register map of the time window record buffer
package twrb_pkg;

   localparam int DEPTH_DEFAULT = 32;
   localparam int RESULT_CAP    = 32;
   localparam int HIT_W         = $clog2(RESULT_CAP + 1);

   localparam int STAMP_W  = 48;
   localparam int STREAM_W = 16;
   localparam int FRAME_W  = 32;
   localparam int PAYLOAD_W = 64;
   localparam int KIND_W   = 2;
   localparam int LIMIT_W  = 6;
   localparam int DUR_W    = 32;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   localparam logic [KIND_W-1:0] KIND_RECORD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FETCH  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RANGE  = 2'd2;

   localparam logic [1:0] REG_ENABLE   = 2'd0;
   localparam logic [1:0] REG_COUNT    = 2'd1;
   localparam logic [1:0] REG_DURATION = 2'd2;

   localparam logic [LIMIT_W-1:0] COUNT_RESET    = 6'd32;
   localparam logic [DUR_W-1:0]   DURATION_RESET = 32'd10000;

   typedef enum logic [1:0] {
      OP_EVICT,
      OP_FETCH,
      OP_RANGE
   } op_type;

   typedef struct packed {
      logic [PAYLOAD_W-1:0] payload;
      logic [FRAME_W-1:0]   frame_number;
      logic [STREAM_W-1:0]  stream_id;
      logic [STAMP_W-1:0]   stamp_ms;
   } entry_type;

   typedef struct packed {
      logic [FRAME_W-1:0]   range_to;
      logic [FRAME_W-1:0]   range_from;
      logic [PAYLOAD_W-1:0] payload;
      logic [FRAME_W-1:0]   frame_number;
      logic [STREAM_W-1:0]  stream_id;
      logic [STAMP_W-1:0]   stamp_ms;
   } req_data_type;

   typedef struct packed {
      logic               record_enable;
      logic [LIMIT_W-1:0] count_limit;
      logic [DUR_W-1:0]   duration_limit_ms;
   } cfg_type;

endpackage

// ===== src/time_window_record_buffer.sv =====
// top level: stream ports, sequencer and result staging of the record buffer
// A record item writes its entry, then reads and tests the oldest entries one by
// one, evicting until one is kept; a fetch or range query reads stored entries
// in turn up to the result cap and is held while the result side stalls.
// Entries are visited one at a time through the single read port of the
// entry memory and the one shared compare unit. The input is not ready while
// an item is in work; a finished result waits in its own output register
// while the next item is taken. Stored entries are only valid inside the live
// window, so no clearing pass runs after reset.
module time_window_record_buffer #(
   parameter int DEPTH = twrb_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // stamp_ms, stream_id, frame_number, payload, range_from, range_to
   input  logic [223:0]                  req_tdata,
   // kind
   input  logic [1:0]                    req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // out_stamp_ms, out_stream_id, out_frame_number, out_payload
   output logic [159:0]                  rsp_tdata,
   // entry_valid
   output logic                          rsp_tuser,
   output logic                          rsp_tlast,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [twrb_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [twrb_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [twrb_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int LW = (CW > twrb_pkg::LIMIT_W) ? CW : twrb_pkg::LIMIT_W;
   localparam int HW = twrb_pkg::HIT_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EV_RD,
      ST_EV_CHK,
      ST_SC_RD,
      ST_SC_CHK,
      ST_DONE
   } state_type;

   state_type                       state_ff;
   logic [AW-1:0]                   head_ff;
   logic [CW-1:0]                   count_ff;
   logic                            armed_ff;
   logic [twrb_pkg::STAMP_W-1:0]    newest_ff;
   twrb_pkg::op_type                query_op_ff;
   logic [twrb_pkg::STREAM_W-1:0]   sid_ff;
   logic [twrb_pkg::FRAME_W-1:0]    lo_ff;
   logic [twrb_pkg::FRAME_W-1:0]    hi_ff;
   logic [AW-1:0]                   scan_slot_ff;
   logic [CW-1:0]                   scan_idx_ff;
   logic [HW-1:0]                   hits_ff;
   logic                            pend_valid_ff;
   twrb_pkg::entry_type             pend_ff;
   logic                            rsp_valid_ff;
   logic                            rsp_flag_ff;
   logic                            rsp_last_ff;
   twrb_pkg::entry_type             rsp_entry_ff;

   twrb_pkg::cfg_type               cfg;
   twrb_pkg::req_data_type          req;
   twrb_pkg::entry_type             rec_entry;
   twrb_pkg::entry_type             rd_entry;
   twrb_pkg::entry_type             hit_entry;
   twrb_pkg::op_type                eval_op;
   logic                            rd_flag;
   logic                            hit;
   logic [twrb_pkg::FRAME_W-1:0]    hit_frame;
   logic                            req_accept;
   logic                            out_free;
   logic                            entry_we;
   logic                            flag_we;
   logic                            flag_wdata;
   logic [AW-1:0]                   waddr;
   logic                            rd_en;
   logic [AW-1:0]                   raddr;
   logic [AW-1:0]                   head_next;
   logic [AW-1:0]                   scan_next;
   logic [AW-1:0]                   head_eff;
   logic [CW-1:0]                   count_eff;
   logic [CW:0]                     slot_sum;
   logic [AW-1:0]                   rec_slot;
   logic [LW-1:0]                   lim;
   logic                            over_count;
   logic                            take;
   logic                            rsp_load;

   twrb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   twrb_mem #(.DEPTH(DEPTH)) u_mem (
      .clock      (clock),
      .entry_we   (entry_we),
      .flag_we    (flag_we),
      .flag_wdata (flag_wdata),
      .waddr      (waddr),
      .wdata      (rec_entry),
      .rd_en      (rd_en),
      .raddr      (raddr),
      .rdata      (rd_entry),
      .rflag      (rd_flag)
   );

   twrb_eval u_eval (
      .op       (eval_op),
      .entry    (rd_entry),
      .fetched  (rd_flag),
      .newest   (newest_ff),
      .duration (cfg.duration_limit_ms),
      .sid      (sid_ff),
      .lo       (lo_ff),
      .hi       (hi_ff),
      .hit      (hit),
      .frame    (hit_frame)
   );

   assign req         = twrb_pkg::req_data_type'(req_tdata);
   assign req_tready  = (state_ff == ST_IDLE);
   assign req_accept  = req_tvalid && req_tready;
   assign out_free    = !rsp_valid_ff || rsp_tready;

   assign rec_entry.stamp_ms     = req.stamp_ms;
   assign rec_entry.stream_id    = req.stream_id;
   assign rec_entry.frame_number = req.frame_number;
   assign rec_entry.payload      = req.payload;

   assign hit_entry.stamp_ms     = rd_entry.stamp_ms;
   assign hit_entry.stream_id    = rd_entry.stream_id;
   assign hit_entry.frame_number = hit_frame;
   assign hit_entry.payload      = rd_entry.payload;

   assign head_next = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign scan_next = (scan_slot_ff == AW'(DEPTH - 1)) ? '0 : scan_slot_ff + 1'b1;

   // append position: fresh history when not armed, oldest dropped when full
   always_comb begin
      if (!armed_ff) begin
         head_eff  = '0;
         count_eff = '0;
      end else if (count_ff >= CW'(DEPTH)) begin
         head_eff  = head_next;
         count_eff = count_ff - 1'b1;
      end else begin
         head_eff  = head_ff;
         count_eff = count_ff;
      end
   end

   assign slot_sum = (CW+1)'(head_eff) + (CW+1)'(count_eff);
   assign rec_slot = (slot_sum >= (CW+1)'(DEPTH)) ? AW'(slot_sum - (CW+1)'(DEPTH))
                                                 : AW'(slot_sum);

   assign lim = (LW'(cfg.count_limit) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(cfg.count_limit);
   assign over_count = LW'(count_ff) > lim;

   assign eval_op = (state_ff == ST_EV_CHK) ? twrb_pkg::OP_EVICT : query_op_ff;
   assign take    = !pend_valid_ff || out_free;

   // output register is loaded this cycle
   assign rsp_load = ((state_ff == ST_SC_CHK) && hit && take && pend_valid_ff)
                  || ((state_ff == ST_DONE) && out_free);

   assign entry_we = req_accept && (req_tuser == twrb_pkg::KIND_RECORD)
                  && cfg.record_enable;
   assign flag_we  = entry_we
                  || ((state_ff == ST_SC_CHK) && hit && take
                      && (query_op_ff == twrb_pkg::OP_FETCH));
   assign flag_wdata = !entry_we;
   assign waddr      = entry_we ? rec_slot : scan_slot_ff;

   assign rd_en = (state_ff == ST_EV_RD) || (state_ff == ST_SC_RD);
   assign raddr = (state_ff == ST_EV_RD) ? head_ff : scan_slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         armed_ff      <= 1'b0;
         hits_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  if (req_tuser == twrb_pkg::KIND_RECORD) begin
                     if (!cfg.record_enable) begin
                        armed_ff <= 1'b0;
                     end else begin
                        head_ff   <= head_eff;
                        count_ff  <= count_eff + 1'b1;
                        newest_ff <= req.stamp_ms;
                        armed_ff  <= 1'b1;
                        state_ff  <= ST_EV_RD;
                     end
                  end else if (req_tuser == twrb_pkg::KIND_FETCH
                               || req_tuser == twrb_pkg::KIND_RANGE) begin
                     pend_valid_ff <= 1'b0;
                     hits_ff       <= '0;
                     if (!cfg.record_enable) begin
                        armed_ff <= 1'b0;
                        state_ff <= ST_DONE;
                     end else begin
                        query_op_ff  <= (req_tuser == twrb_pkg::KIND_FETCH)
                                        ? twrb_pkg::OP_FETCH : twrb_pkg::OP_RANGE;
                        sid_ff       <= req.stream_id;
                        lo_ff        <= req.range_from;
                        hi_ff        <= req.range_to;
                        scan_slot_ff <= head_ff;
                        scan_idx_ff  <= '0;
                        state_ff     <= ST_SC_RD;
                     end
                  end
               end
            end
            ST_EV_RD: begin
               state_ff <= (count_ff > CW'(1)) ? ST_EV_CHK : ST_IDLE;
            end
            ST_EV_CHK: begin
               if (hit || over_count) begin
                  head_ff  <= head_next;
                  count_ff <= count_ff - 1'b1;
                  state_ff <= ST_EV_RD;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_SC_RD: begin
               if (scan_idx_ff < count_ff && hits_ff < HW'(twrb_pkg::RESULT_CAP)) begin
                  state_ff <= ST_SC_CHK;
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            ST_SC_CHK: begin
               if (!hit || take) begin
                  if (hit) begin
                     if (pend_valid_ff) begin
                        rsp_valid_ff <= 1'b1;
                        rsp_flag_ff  <= 1'b1;
                        rsp_last_ff  <= 1'b0;
                        rsp_entry_ff <= pend_ff;
                     end
                     pend_ff       <= hit_entry;
                     pend_valid_ff <= 1'b1;
                     hits_ff       <= hits_ff + 1'b1;
                  end
                  scan_slot_ff <= scan_next;
                  scan_idx_ff  <= scan_idx_ff + 1'b1;
                  state_ff     <= ST_SC_RD;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_last_ff  <= 1'b1;
                  rsp_flag_ff  <= pend_valid_ff;
                  rsp_entry_ff <= pend_valid_ff ? pend_ff : '0;
                  pend_valid_ff <= 1'b0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_entry_ff;
   assign rsp_tuser  = rsp_flag_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      head_ff <= AW'(DEPTH - 1))
      else $error("head pointer out of range");

   a_hits_bound: assert property (@(posedge clock) disable iff (reset)
      hits_ff <= HW'(twrb_pkg::RESULT_CAP))
      else $error("result cap exceeded");

   a_record_fills: assert property (@(posedge clock) disable iff (reset)
      entry_we |=> (count_ff != '0) && armed_ff)
      else $error("append left history empty");

   a_done_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) && out_free |=> rsp_valid_ff && rsp_last_ff)
      else $error("query closed without final word");
`endif

endmodule

// ===== src/twrb_csr.sv =====
// configuration registers behind the apb-style port
module twrb_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [twrb_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [twrb_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [twrb_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready,
   output twrb_pkg::cfg_type             cfg
);

   logic                               enable_ff;
   logic [twrb_pkg::LIMIT_W-1:0]       limit_ff;
   logic [twrb_pkg::DUR_W-1:0]         duration_ff;
   logic                               write_en;
   logic [1:0]                         reg_index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b1;
         limit_ff    <= twrb_pkg::COUNT_RESET;
         duration_ff <= twrb_pkg::DURATION_RESET;
      end else if (write_en) begin
         case (reg_index)
            twrb_pkg::REG_ENABLE:   enable_ff   <= csr_pwdata[0];
            twrb_pkg::REG_COUNT:    limit_ff    <= csr_pwdata[twrb_pkg::LIMIT_W-1:0];
            twrb_pkg::REG_DURATION: duration_ff <= csr_pwdata[twrb_pkg::DUR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         twrb_pkg::REG_ENABLE:
            csr_prdata = {{(twrb_pkg::CSR_DW-1){1'b0}}, enable_ff};
         twrb_pkg::REG_COUNT:
            csr_prdata = {{(twrb_pkg::CSR_DW-twrb_pkg::LIMIT_W){1'b0}}, limit_ff};
         twrb_pkg::REG_DURATION:
            csr_prdata = duration_ff;
         default:
            csr_prdata = '0;
      endcase
   end

   assign cfg.record_enable     = enable_ff;
   assign cfg.count_limit       = limit_ff;
   assign cfg.duration_limit_ms = duration_ff;

endmodule

// ===== src/twrb_mem.sv =====
// entry memory and fetched flags, one write port and one registered read port
module twrb_mem #(
   parameter int DEPTH = twrb_pkg::DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       entry_we,
   input  logic                       flag_we,
   input  logic                       flag_wdata,
   input  logic [$clog2(DEPTH)-1:0]   waddr,
   input  twrb_pkg::entry_type        wdata,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   raddr,
   output twrb_pkg::entry_type        rdata,
   output logic                       rflag
);

   twrb_pkg::entry_type entry_mem_ff [DEPTH];
   logic                flag_mem_ff  [DEPTH];
   twrb_pkg::entry_type rdata_ff;
   logic                rflag_ff;

   always_ff @(posedge clock) begin
      if (entry_we) begin
         entry_mem_ff[waddr] <= wdata;
      end
      if (flag_we) begin
         flag_mem_ff[waddr] <= flag_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= entry_mem_ff[raddr];
         rflag_ff <= flag_mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
   assign rflag = rflag_ff;

endmodule

// ===== src/twrb_eval.sv =====
// shared compare unit: eviction test, fetch test and range match with rebasing
module twrb_eval (
   input  twrb_pkg::op_type                 op,
   input  twrb_pkg::entry_type              entry,
   input  logic                             fetched,
   input  logic [twrb_pkg::STAMP_W-1:0]     newest,
   input  logic [twrb_pkg::DUR_W-1:0]       duration,
   input  logic [twrb_pkg::STREAM_W-1:0]    sid,
   input  logic [twrb_pkg::FRAME_W-1:0]     lo,
   input  logic [twrb_pkg::FRAME_W-1:0]     hi,
   output logic                             hit,
   output logic [twrb_pkg::FRAME_W-1:0]     frame
);

   logic [twrb_pkg::STAMP_W-1:0] span;
   logic                         too_old;
   logic                         in_range;

   assign span    = newest - entry.stamp_ms;
   assign too_old = (newest < entry.stamp_ms)
                 || (span > {{(twrb_pkg::STAMP_W-twrb_pkg::DUR_W){1'b0}}, duration});
   assign in_range = (entry.stream_id == sid)
                  && (entry.frame_number >= lo) && (entry.frame_number <= hi);

   always_comb begin
      case (op)
         twrb_pkg::OP_EVICT: begin
            hit   = too_old;
            frame = entry.frame_number;
         end
         twrb_pkg::OP_FETCH: begin
            hit   = !fetched;
            frame = entry.frame_number;
         end
         twrb_pkg::OP_RANGE: begin
            hit   = in_range;
            frame = entry.frame_number - lo;
         end
         default: begin
            hit   = 1'b0;
            frame = entry.frame_number;
         end
      endcase
   end

endmodule
